FILE: rtl/byte_level_token_text_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte-level token text decoder
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BYTE_LEVEL_TOKEN_TEXT_DECODER_TOP_ASSERT_SVH
`define BYTE_LEVEL_TOKEN_TEXT_DECODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising clock edge.
`define BLTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bltd assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BLTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bltd assertion failed");

`else

`define BLTD_ASSERT_NOW(label, ante, cons)
`define BLTD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/bltd_pkg.sv
// ----------------------------------------------------------------------------
// Byte-level token text decoder package
// Result types and the two-byte remap decode functions.
// ----------------------------------------------------------------------------
package bltd_pkg;

    // Lead bytes that can open a mapped two-byte sequence.
    localparam logic [7:0] LeadLo = 8'hC2;
    localparam logic [7:0] LeadHi = 8'hC5;

    // Mapped code point window and the single hole in it.
    localparam logic [10:0] CpLo   = 11'h0A1;
    localparam logic [10:0] CpHi   = 11'h143;
    localparam logic [10:0] CpHole = 11'h0AD;
    localparam logic [10:0] CpHigh = 11'h100;

    // Boundaries of the shifted ranges above 0xFF.
    localparam logic [6:0] IdxLowRun  = 7'd33;
    localparam logic [6:0] IdxHighRun = 7'd67;
    localparam logic [7:0] DelOffset  = 8'h5E;
    localparam logic [7:0] SoftHyphen = 8'hAD;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       piece_done;
    } res_t;

    // Everything one input item causes, plus the next hold state.
    typedef struct packed {
        logic       res0_valid;
        res_t       res0;
        logic       res1_valid;
        res_t       res1;
        logic       held_valid;
        logic [7:0] held_lead;
    } step_t;

    function automatic logic is_lead(input logic [7:0] b);
        return (b >= LeadLo) && (b <= LeadHi);
    endfunction

    // Code point of a lead/continuation pair (valid only for a lead byte).
    function automatic logic [10:0] pair_cp(input logic [7:0] lead, input logic [7:0] cont);
        return {lead[4:0], cont[5:0]};
    endfunction

    // True when the pair forms a mapped code point.
    function automatic logic pair_match(input logic [7:0] lead, input logic [7:0] cont);
        logic [10:0] cp;
        cp = pair_cp(lead, cont);
        return is_lead(lead) && (cont[7:6] == 2'b10)
            && (cp >= CpLo) && (cp <= CpHi) && (cp != CpHole);
    endfunction

    // Raw byte for a matched pair.
    function automatic logic [7:0] pair_raw(input logic [7:0] lead, input logic [7:0] cont);
        logic [10:0] cp;
        logic [6:0]  idx;
        logic [7:0]  raw;
        cp  = pair_cp(lead, cont);
        idx = cp[6:0];
        if (cp < CpHigh)
        begin
            raw = cp[7:0];
        end
        else if (idx < IdxLowRun)
        begin
            raw = {1'b0, idx};
        end
        else if (idx < IdxHighRun)
        begin
            raw = {1'b0, idx} + DelOffset;
        end
        else
        begin
            raw = SoftHyphen;
        end
        return raw;
    endfunction

endpackage

FILE: rtl/bltd_in_if.sv
// ----------------------------------------------------------------------------
// Input channel interface
// Carries one encoded byte of a token piece per request.
// ----------------------------------------------------------------------------
interface bltd_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       piece_end;

    modport source (output valid, output in_byte, output piece_end, input ready);
    modport sink   (input valid, input in_byte, input piece_end, output ready);

endinterface

FILE: rtl/bltd_out_if.sv
// ----------------------------------------------------------------------------
// Output channel interface
// Carries one decoded byte per request with its run and piece flags.
// ----------------------------------------------------------------------------
interface bltd_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       piece_done;

    modport source (output valid, output out_byte, output run_last, output piece_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input piece_done,
                    output ready);

endinterface

FILE: rtl/bltd_decode.sv
// ----------------------------------------------------------------------------
// Byte decode step
// Combines the held lead byte with the incoming byte and yields up to two
// results together with the next hold state.
// ----------------------------------------------------------------------------
module bltd_decode (
    input  logic               held_valid,
    input  logic [7:0]         held_lead,
    input  logic [7:0]         in_byte,
    input  logic               piece_end,
    output bltd_pkg::step_t    step
);

    logic pair_ok;
    logic lead_in;

    assign pair_ok = held_valid && bltd_pkg::pair_match(held_lead, in_byte);
    assign lead_in = bltd_pkg::is_lead(in_byte) && !piece_end;

    // Pick the results and the next hold state.
    always_comb
    begin
        step                 = '0;
        step.res0.out_byte   = in_byte;
        step.res1.out_byte   = in_byte;
        step.held_lead       = 8'h00;
        step.held_valid      = 1'b0;
        if (pair_ok)
        begin
            step.res0_valid    = 1'b1;
            step.res0.out_byte = bltd_pkg::pair_raw(held_lead, in_byte);
            step.res0.run_last = 1'b1;
            step.res0.piece_done = piece_end;
        end
        else if (held_valid)
        begin
            // The held byte goes out unchanged; the new byte starts over.
            step.res0_valid    = 1'b1;
            step.res0.out_byte = held_lead;
            if (lead_in)
            begin
                step.res0.run_last = 1'b1;
                step.held_valid    = 1'b1;
                step.held_lead     = in_byte;
            end
            else
            begin
                step.res1_valid      = 1'b1;
                step.res1.run_last   = 1'b1;
                step.res1.piece_done = piece_end;
            end
        end
        else if (lead_in)
        begin
            step.held_valid = 1'b1;
            step.held_lead  = in_byte;
        end
        else
        begin
            step.res0_valid      = 1'b1;
            step.res0.run_last   = 1'b1;
            step.res0.piece_done = piece_end;
        end
    end

endmodule

FILE: rtl/byte_level_token_text_decoder_top.sv
// ----------------------------------------------------------------------------
// Byte-level token text decoder
// Turns the remapped UTF-8 bytes of a token piece back into raw bytes.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Payload                          | Handshake
//  piece    | in        | in_byte[7:0], piece_end          | valid/ready
//  decoded  | out       | out_byte[7:0], run_last, piece_done | valid/ready
//
// One byte is taken per cycle while ready is high; its first result, if any,
// appears in the next cycle. A byte that yields two results holds off the next
// request while its second result is in the one-deep queue behind the register.
// Output stalls propagate to input ready only when that queue is occupied
// or the result register is full and not being taken.
// Reset clears the held lead byte and both result slots; no clearing pass.
// ----------------------------------------------------------------------------
`include "byte_level_token_text_decoder_top_assert.svh"

module byte_level_token_text_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    bltd_in_if.sink     piece,
    bltd_out_if.source  decoded
);

    logic            held_valid_reg;
    logic            held_valid_next;
    logic [7:0]      held_lead_reg;
    logic [7:0]      held_lead_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    bltd_pkg::res_t  out_reg;
    bltd_pkg::res_t  out_next;
    logic            extra_valid_reg;
    logic            extra_valid_next;
    bltd_pkg::res_t  extra_reg;
    bltd_pkg::res_t  extra_next;
    bltd_pkg::step_t step;
    logic            accept;
    logic            pop;

    // Decode the incoming byte against the held lead.
    bltd_decode u_decode (
        .held_valid (held_valid_reg),
        .held_lead  (held_lead_reg),
        .in_byte    (piece.in_byte),
        .piece_end  (piece.piece_end),
        .step       (step)
    );

    // Handshakes.
    assign piece.ready = !extra_valid_reg && (!out_valid_reg || decoded.ready);
    assign accept      = piece.valid && piece.ready;
    assign pop         = out_valid_reg && decoded.ready;

    assign decoded.valid      = out_valid_reg;
    assign decoded.out_byte   = out_reg.out_byte;
    assign decoded.run_last   = out_reg.run_last;
    assign decoded.piece_done = out_reg.piece_done;

    // Next hold state and result slots.
    always_comb
    begin
        held_valid_next  = held_valid_reg;
        held_lead_next   = held_lead_reg;
        out_valid_next   = out_valid_reg;
        out_next         = out_reg;
        extra_valid_next = extra_valid_reg;
        extra_next       = extra_reg;
        if (accept)
        begin
            held_valid_next  = step.held_valid;
            held_lead_next   = step.held_lead;
            out_valid_next   = step.res0_valid;
            out_next         = step.res0;
            extra_valid_next = step.res1_valid;
            extra_next       = step.res1;
        end
        else if (pop)
        begin
            out_valid_next   = extra_valid_reg;
            out_next         = extra_reg;
            extra_valid_next = 1'b0;
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg  <= 1'b0;
            held_lead_reg   <= 8'h00;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            extra_valid_reg <= 1'b0;
            extra_reg       <= '0;
        end
        else
        begin
            held_valid_reg  <= held_valid_next;
            held_lead_reg   <= held_lead_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
            extra_valid_reg <= extra_valid_next;
            extra_reg       <= extra_next;
        end
    end

    // The queued second result always sits behind a shown result.
    `BLTD_ASSERT_NOW(a_extra_behind_out, extra_valid_reg, out_valid_reg)
    // Only a lead byte is ever held.
    `BLTD_ASSERT_NOW(a_held_is_lead, held_valid_reg, bltd_pkg::is_lead(held_lead_reg))
    // The end of a piece never leaves a byte held.
    `BLTD_ASSERT_NEXT(a_end_flushes, accept && piece.piece_end, !held_valid_reg)
    // The final result of a piece is also the last of its run.
    `BLTD_ASSERT_NOW(a_done_is_last, out_valid_reg && out_reg.piece_done, out_reg.run_last)

endmodule
